// ===== hdl/priority_table_max_extract_assert.svh =====
// Assertion macros used by ptme_dp.
// Define NO_ASSERTIONS to compile them out.
`ifndef PRIORITY_TABLE_MAX_EXTRACT_ASSERT_SVH
`define PRIORITY_TABLE_MAX_EXTRACT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clk edge out of reset.
`define PTME_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptme assertion failed");
// Next-cycle implication.
`define PTME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptme assertion failed");
`else
`define PTME_ASSERT(lbl, ante, cons)
`define PTME_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/ptme_pkg.sv =====
package ptme_pkg;

    // Default sizing
    localparam int ENTRIES_DEF = 64;
    localparam int DATA_W_DEF  = 32;
    localparam int PRIO_W_DEF  = 16;

    // Fixed field widths on the stream ports
    localparam int FUNC_W      = 3;
    localparam int ID_W        = 6;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_PRIO_W  = 16;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 64;

    // Internal scratch widths for zero-extension before truncation
    localparam int WIDE_W      = 64;
    localparam int CMP_W       = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD     = 3'd0,
        FN_PROMOTE = 3'd1,
        FN_PEEK    = 3'd2,
        FN_POP     = 3'd3,
        FN_CHECK   = 3'd4,
        FN_READ    = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BADID = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic load_req;    // capture the request fields
        logic rd_item;     // read both tables at the request id
        logic scan_start;  // clear the max search
        logic scan_step;   // advance the max search
        logic rd_best;     // read data of the winning entry
        logic exec;        // commit table updates, form the result
        logic out_load;    // move the result into the output register
    } ptme_cmd_t;

    typedef struct packed {
        func_t func;       // function of the held request
        logic  scan_done;  // all live candidates compared
        logic  out_free;   // output register can take a result
    } ptme_stat_t;

endpackage

// ===== hdl/ptme_ctrl.sv =====
module ptme_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ptme_pkg::ptme_stat_t stat,
    output ptme_pkg::ptme_cmd_t  cmd
);
    import ptme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_req = 1'b1;
                    ready_next   = 1'b0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.func)
                    FN_PEEK, FN_POP:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    FN_PROMOTE, FN_CHECK, FN_READ:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_EXEC;
                    end
                    default:
                    begin
                        state_next = S_EXEC;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.rd_best = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== hdl/ptme_dp.sv =====
`include "priority_table_max_extract_assert.svh"

module ptme_dp #(
    parameter int ENTRIES = ptme_pkg::ENTRIES_DEF,
    parameter int DATA_W  = ptme_pkg::DATA_W_DEF,
    parameter int PRIO_W  = ptme_pkg::PRIO_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptme_pkg::ptme_cmd_t             cmd,
    output ptme_pkg::ptme_stat_t            stat,
    input  logic [ptme_pkg::FUNC_W-1:0]     item_func,
    input  logic [ptme_pkg::ID_W-1:0]       item_id,
    input  logic [ptme_pkg::IN_DATA_W-1:0]  item_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ptme_pkg::ID_W-1:0]       out_id,
    output logic [ptme_pkg::OUT_DATA_W-1:0] out_data,
    output logic [ptme_pkg::OUT_PRIO_W-1:0] out_priority,
    output logic                            out_live,
    output logic [ptme_pkg::STATUS_W-1:0]   status
);
    import ptme_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int META_W = PRIO_W + 1;   // {live, priority}

    // Tables: one write and one registered read port each
    logic [DATA_W-1:0] data_mem [ENTRIES];
    logic [META_W-1:0] meta_mem [ENTRIES];
    logic [DATA_W-1:0] data_q;
    logic [META_W-1:0] meta_q;

    // Held request
    func_t                func_reg;
    logic [ID_W-1:0]      id_reg;
    logic [IN_DATA_W-1:0] data_reg;

    // Allocation and search state
    logic [CNT_W-1:0]  next_id_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              cmp_v_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;

    // Result and output registers
    logic [ID_W-1:0]       res_id_reg,   res_id_next;
    logic [OUT_DATA_W-1:0] res_data_reg, res_data_next;
    logic [OUT_PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic                  res_live_reg, res_live_next;
    status_t               res_st_reg,   res_st_next;
    logic                  m_valid_reg;
    logic [ID_W-1:0]       m_id_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_PRIO_W-1:0] m_prio_reg;
    logic                  m_live_reg;
    status_t               m_st_reg;

    logic [CMP_W-1:0]  id_wide;
    logic [CMP_W-1:0]  nid_wide;
    logic [CMP_W-1:0]  best_wide;
    logic [IDX_W-1:0]  id_idx;
    logic              id_known;
    logic              item_live;
    logic              table_full;
    logic              scan_more;
    logic              cand;
    logic [IDX_W-1:0]  meta_raddr;
    logic [IDX_W-1:0]  data_raddr;
    logic              meta_we;
    logic [IDX_W-1:0]  meta_waddr;
    logic [META_W-1:0] meta_wdata;
    logic              data_we;
    logic              nid_inc;
    logic [PRIO_W-1:0] prio_cur;
    logic [PRIO_W-1:0] prio_inc;
    logic [WIDE_W-1:0] prio_inc_wide;
    logic [WIDE_W-1:0] best_prio_wide;
    logic [WIDE_W-1:0] data_q_wide;
    logic [WIDE_W-1:0] wdata_wide;

    assign id_wide    = CMP_W'(id_reg);
    assign nid_wide   = CMP_W'(next_id_reg);
    assign best_wide  = CMP_W'(best_idx_reg);
    assign id_idx     = id_wide[IDX_W-1:0];
    assign id_known   = id_wide < nid_wide;
    assign item_live  = id_known && meta_q[PRIO_W];
    assign table_full = next_id_reg == CNT_W'(ENTRIES);
    assign scan_more  = scan_idx_reg < next_id_reg;

    // A live entry at or above the current best wins: ties go to the later id
    assign cand = cmp_v_reg && meta_q[PRIO_W]
                  && (!found_reg || meta_q[PRIO_W-1:0] >= best_prio_reg);

    assign meta_raddr = cmd.scan_step ? scan_idx_reg[IDX_W-1:0] : id_idx;
    assign data_raddr = cmd.rd_best ? best_idx_reg : id_idx;

    assign prio_cur       = meta_q[PRIO_W-1:0];
    assign prio_inc       = (prio_cur == {PRIO_W{1'b1}}) ? prio_cur : prio_cur + 1'b1;
    assign prio_inc_wide  = WIDE_W'(prio_inc);
    assign best_prio_wide = WIDE_W'(best_prio_reg);
    assign data_q_wide    = WIDE_W'(data_q);
    assign wdata_wide     = WIDE_W'(data_reg);

    assign stat.func      = func_reg;
    assign stat.scan_done = !scan_more && !cmp_v_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Table updates and result of the held request
    always_comb
    begin
        meta_we       = 1'b0;
        meta_waddr    = id_idx;
        meta_wdata    = {1'b1, prio_inc};
        data_we       = 1'b0;
        nid_inc       = 1'b0;
        res_id_next   = '0;
        res_data_next = '0;
        res_prio_next = '0;
        res_live_next = 1'b0;
        res_st_next   = ST_OK;
        unique case (func_reg)
            FN_ADD:
            begin
                if (table_full)
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    meta_we     = cmd.exec;
                    data_we     = cmd.exec;
                    nid_inc     = cmd.exec;
                    meta_waddr  = next_id_reg[IDX_W-1:0];
                    meta_wdata  = {1'b1, {PRIO_W{1'b0}}};
                    res_id_next = nid_wide[ID_W-1:0];
                end
            end
            FN_PROMOTE:
            begin
                res_id_next = id_reg;
                if (!item_live)
                begin
                    res_st_next = ST_BADID;
                end
                else
                begin
                    meta_we       = cmd.exec;
                    res_prio_next = prio_inc_wide[OUT_PRIO_W-1:0];
                end
            end
            FN_PEEK, FN_POP:
            begin
                if (!found_reg)
                begin
                    res_st_next = ST_EMPTY;
                end
                else
                begin
                    res_id_next   = best_wide[ID_W-1:0];
                    res_data_next = data_q_wide[OUT_DATA_W-1:0];
                    res_prio_next = best_prio_wide[OUT_PRIO_W-1:0];
                    meta_we       = cmd.exec && (func_reg == FN_POP);
                    meta_waddr    = best_idx_reg;
                    meta_wdata    = {1'b0, best_prio_reg};
                end
            end
            FN_CHECK:
            begin
                res_id_next   = id_reg;
                res_live_next = item_live;
            end
            FN_READ:
            begin
                res_id_next = id_reg;
                if (!item_live)
                begin
                    res_st_next = ST_BADID;
                end
                else
                begin
                    res_data_next = data_q_wide[OUT_DATA_W-1:0];
                end
            end
            default:
            begin
                res_st_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (cmd.rd_item || cmd.scan_step)
        begin
            meta_q <= meta_mem[meta_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[next_id_reg[IDX_W-1:0]] <= wdata_wide[DATA_W-1:0];
        end
        if (cmd.rd_item || cmd.rd_best)
        begin
            data_q <= data_mem[data_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg <= '0;
            cmp_v_reg   <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (nid_inc)
            begin
                next_id_reg <= next_id_reg + 1'b1;
            end
            cmp_v_reg <= cmd.scan_step && scan_more;
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (cand)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= func_t'(item_func);
            id_reg   <= item_id;
            data_reg <= item_data;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step && scan_more)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if (cand)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_prio_reg <= meta_q[PRIO_W-1:0];
        end
        if (cmd.exec)
        begin
            res_id_reg   <= res_id_next;
            res_data_reg <= res_data_next;
            res_prio_reg <= res_prio_next;
            res_live_reg <= res_live_next;
            res_st_reg   <= res_st_next;
        end
        if (cmd.out_load)
        begin
            m_id_reg   <= res_id_reg;
            m_data_reg <= res_data_reg;
            m_prio_reg <= res_prio_reg;
            m_live_reg <= res_live_reg;
            m_st_reg   <= res_st_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign out_id       = m_id_reg;
    assign out_data     = m_data_reg;
    assign out_priority = m_prio_reg;
    assign out_live     = m_live_reg;
    assign status       = m_st_reg;

    `PTME_ASSERT(a_next_id_range, 1'b1, next_id_reg <= CNT_W'(ENTRIES))
    `PTME_ASSERT_NEXT(a_cmp_drains, !cmd.scan_step, !cmp_v_reg)
    `PTME_ASSERT(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready)
    `PTME_ASSERT(a_best_allocated, found_reg, CNT_W'(best_idx_reg) < next_id_reg)

endmodule

// ===== hdl/priority_table_max_extract.sv =====
// Priority table with max extract.
// Request stream (s_*): one transfer carries func, item_id and item_data.
//   func: add, promote, peek max, pop max, check valid, read data.
// Result stream (m_*): exactly one result transfer per request, in order.
// Add, promote, check and read go from dispatch straight to execute; peek
//   and pop first run the max search, which reads the priority table one
//   entry per cycle through its single read port over ids 0 to next_id - 1,
//   where next_id is the number of adds made so far (at most ENTRIES).
// One request is in flight at a time; s_tready is high only while idle, so
//   the next request is taken only once the last result has moved into the
//   output register.
// A finished result sits in an output register, so the next request is
//   taken while the receiver still stalls; that request then waits in the
//   done state until the output register frees up.
// Reset: all entries retired, id counter at zero, no result pending. The
//   data and priority tables need no clearing; ids past the counter are
//   never taken as live or scanned.
module priority_table_max_extract #(
    parameter int ENTRIES = ptme_pkg::ENTRIES_DEF,
    parameter int DATA_W  = ptme_pkg::DATA_W_DEF,
    parameter int PRIO_W  = ptme_pkg::PRIO_W_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] func, [8:3] item_id, [40:9] item_data, [47:41] zero
    input  logic [ptme_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [5:0] out_id, [37:6] out_data, [53:38] out_priority, [54] out_live,
    // [56:55] status, [63:57] zero
    output logic [ptme_pkg::M_TDATA_W-1:0] m_tdata
);
    import ptme_pkg::*;

    localparam int PAD_W = M_TDATA_W - ID_W - OUT_DATA_W - OUT_PRIO_W - 1 - STATUS_W;

    ptme_cmd_t  cmd;
    ptme_stat_t stat;

    // Request fields, lowest bits first
    logic [FUNC_W-1:0]     item_func;
    logic [ID_W-1:0]       item_id;
    logic [IN_DATA_W-1:0]  item_data;

    // Result fields
    logic [ID_W-1:0]       out_id;
    logic [OUT_DATA_W-1:0] out_data;
    logic [OUT_PRIO_W-1:0] out_priority;
    logic                  out_live;
    logic [STATUS_W-1:0]   status;

    assign item_func = s_tdata[FUNC_W-1:0];
    assign item_id   = s_tdata[FUNC_W +: ID_W];
    assign item_data = s_tdata[FUNC_W + ID_W +: IN_DATA_W];

    assign m_tdata = {{PAD_W{1'b0}}, status, out_live, out_priority, out_data, out_id};

    // Sequencer: idle, dispatch, scan, execute, done
    ptme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tables, id counter, max search and result registers
    ptme_dp #(
        .ENTRIES (ENTRIES),
        .DATA_W  (DATA_W),
        .PRIO_W  (PRIO_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_func    (item_func),
        .item_id      (item_id),
        .item_data    (item_data),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .out_id       (out_id),
        .out_data     (out_data),
        .out_priority (out_priority),
        .out_live     (out_live),
        .status       (status)
    );

endmodule
